>>> hw/rtl/assert_macros.svh
// Assertion macros for the decoder RTL; included by u8d_decode.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define U8D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define U8D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/u8d_pkg.sv
// Shared types, codes and byte constants for the UTF-8 decoder.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps

package u8d_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } u8d_byte_t;

  typedef struct packed {
    logic [30:0] code_point;
    logic [1:0]  status;
    logic        last_of_string;
  } u8d_result_t;

  // decode step output toward the result register
  typedef struct packed {
    logic        emit;
    u8d_result_t item;
  } u8d_step_t;

  localparam logic [1:0] STATUS_CHAR     = 2'd0;
  localparam logic [1:0] STATUS_ERROR    = 2'd1;
  localparam logic [1:0] STATUS_DROP_END = 2'd2;

  localparam logic [7:0] LEAD_2_MIN = 8'hC2;
  localparam logic [7:0] LEAD_3_MIN = 8'hE0;
  localparam logic [7:0] LEAD_4_MIN = 8'hF0;
  localparam logic [7:0] LEAD_5_MIN = 8'hF8;
  localparam logic [7:0] LEAD_6_MIN = 8'hFC;
  localparam logic [7:0] LEAD_BAD   = 8'hFE;

  localparam logic [7:0] SECOND_MIN_3 = 8'hA0;
  localparam logic [7:0] SECOND_MIN_4 = 8'h90;
  localparam logic [7:0] SECOND_MIN_5 = 8'h88;
  localparam logic [7:0] SECOND_MIN_6 = 8'h84;
  localparam logic [7:0] CONT_MIN     = 8'h80;

  // payload bits of a lead byte, by number of continuation bytes to follow
  function automatic logic [7:0] lead_mask(input logic [2:0] rem);
    logic [7:0] m;
    case (rem)
      3'd1:    m = 8'h1F;
      3'd2:    m = 8'h0F;
      3'd3:    m = 8'h07;
      3'd4:    m = 8'h03;
      3'd5:    m = 8'h01;
      default: m = 8'h3F;
    endcase
    return m;
  endfunction

  // lowest legal second byte after a lead that can be overlong
  function automatic logic [7:0] second_min(input logic [2:0] rem);
    logic [7:0] m;
    case (rem)
      3'd2:    m = SECOND_MIN_3;
      3'd3:    m = SECOND_MIN_4;
      3'd4:    m = SECOND_MIN_5;
      3'd5:    m = SECOND_MIN_6;
      default: m = CONT_MIN;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/utf8_to_code_point_decoder.sv
// UTF-8 decoder, 1 to 6 byte forms: one byte in per cycle unless stalled, one code point
// per character. A taken byte waits in the input register and is decoded into the output
// register once that is free, and stays held while a stalled result waits there.
// Throughput: one byte per cycle unless stalled; a waiting result stalls a full input stage.
// Reset (rst, synchronous): empties both registers, clears the sequence state, stalls input.
// Depends on u8d_pkg, u8d_in_stage, u8d_decode, u8d_out_stage.
`timescale 1ns / 1ps

module utf8_to_code_point_decoder import u8d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  u8d_byte_t   byte_data,
  output logic        cp_valid,
  input  logic        cp_stall,
  output u8d_result_t cp_data
);

  logic      held;
  logic      res_free;
  logic      fire;
  logic      take;
  u8d_byte_t item;
  u8d_step_t step;

  // the held byte moves on whenever the result register can take a transfer
  assign res_free   = !cp_valid || !cp_stall;
  assign fire       = held && res_free;
  assign byte_stall = rst || (held && !res_free);
  assign take       = byte_valid && !byte_stall;

  u8d_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .fire      (fire),
    .byte_data (byte_data),
    .held      (held),
    .item      (item)
  );

  u8d_decode u_dec (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .step (step)
  );

  u8d_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .step     (step),
    .cp_stall (cp_stall),
    .cp_valid (cp_valid),
    .cp_data  (cp_data)
  );

endmodule

>>> hw/rtl/u8d_in_stage.sv
// Input register of the UTF-8 decoder: holds one byte until decoded.
// Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_in_stage import u8d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  logic      fire,
  input  u8d_byte_t byte_data,
  output logic      held,
  output u8d_byte_t item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (fire) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= byte_data;
    end
  end

endmodule

>>> hw/rtl/u8d_decode.sv
// Decode step: sequence state registers and the per-byte update logic.
// Depends on u8d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8d_decode import u8d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  u8d_byte_t item,
  output u8d_step_t step
);

  logic [2:0]  rem;
  logic [30:0] partial;
  logic        chk;
  logic        drop;

  logic [2:0]  rem_next;
  logic [30:0] partial_next;
  logic        chk_next;
  logic        drop_next;

  logic [7:0]  b;
  logic        last;
  logic [2:0]  lead_rem;
  logic        cont_ok;
  logic [30:0] shifted;
  logic [2:0]  rem_dec;

  logic        emit_now;
  logic        drop_end_now;
  logic        last_now;

  assign b       = item.byte_in;
  assign last    = item.end_of_string;
  assign shifted = {partial[24:0], b[5:0]};
  assign rem_dec = rem - 3'd1;

  always_comb begin
    case (b) inside
      [LEAD_2_MIN : LEAD_3_MIN - 8'd1]: lead_rem = 3'd1;
      [LEAD_3_MIN : LEAD_4_MIN - 8'd1]: lead_rem = 3'd2;
      [LEAD_4_MIN : LEAD_5_MIN - 8'd1]: lead_rem = 3'd3;
      [LEAD_5_MIN : LEAD_6_MIN - 8'd1]: lead_rem = 3'd4;
      [LEAD_6_MIN : LEAD_BAD - 8'd1]:   lead_rem = 3'd5;
      default:                          lead_rem = 3'd0;
    endcase
  end

  assign cont_ok = (b[7:6] == 2'b10) && !(chk && (b < second_min(rem)));

  always_comb begin
    rem_next     = rem;
    partial_next = partial;
    chk_next     = chk;
    drop_next    = drop;
    step         = '0;
    if (drop) begin
      if (last) begin
        drop_next                = 1'b0;
        step.emit                = 1'b1;
        step.item.status         = STATUS_DROP_END;
        step.item.last_of_string = 1'b1;
      end
    end else if (rem == 3'd0) begin
      if (!b[7]) begin
        step.emit                = 1'b1;
        step.item.code_point     = {23'd0, b};
        step.item.status         = STATUS_CHAR;
        step.item.last_of_string = last;
        if (last) begin
          partial_next = '0;
          chk_next     = 1'b0;
        end
      end else if (lead_rem == 3'd0 || last) begin
        // bad lead, or a lead cut off by the end of the string
        partial_next             = '0;
        chk_next                 = 1'b0;
        drop_next                = !last;
        step.emit                = 1'b1;
        step.item.status         = STATUS_ERROR;
        step.item.last_of_string = last;
      end else begin
        rem_next     = lead_rem;
        partial_next = {23'd0, b & lead_mask(lead_rem)};
        chk_next     = (b == LEAD_3_MIN) || (b == LEAD_4_MIN) ||
                       (b == LEAD_5_MIN) || (b == LEAD_6_MIN);
      end
    end else begin
      if (!cont_ok) begin
        rem_next                 = 3'd0;
        partial_next             = '0;
        chk_next                 = 1'b0;
        drop_next                = !last;
        step.emit                = 1'b1;
        step.item.status         = STATUS_ERROR;
        step.item.last_of_string = last;
      end else if (rem_dec == 3'd0) begin
        rem_next                 = 3'd0;
        partial_next             = '0;
        chk_next                 = 1'b0;
        step.emit                = 1'b1;
        step.item.code_point     = shifted;
        step.item.status         = STATUS_CHAR;
        step.item.last_of_string = last;
      end else if (last) begin
        // string ended inside a sequence
        rem_next                 = 3'd0;
        partial_next             = '0;
        chk_next                 = 1'b0;
        step.emit                = 1'b1;
        step.item.status         = STATUS_ERROR;
        step.item.last_of_string = 1'b1;
      end else begin
        rem_next     = rem_dec;
        partial_next = shifted;
        chk_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem     <= 3'd0;
      partial <= '0;
      chk     <= 1'b0;
      drop    <= 1'b0;
    end else if (fire) begin
      rem     <= rem_next;
      partial <= partial_next;
      chk     <= chk_next;
      drop    <= drop_next;
    end
  end

  assign emit_now     = fire && step.emit;
  assign drop_end_now = emit_now && (step.item.status == STATUS_DROP_END);
  assign last_now     = emit_now && step.item.last_of_string;

  `U8D_ASSERT_ALWAYS(a_drop_no_seq, drop |-> (rem == 3'd0), "dropping inside a sequence")
  `U8D_ASSERT_ALWAYS(a_chk_range, chk |-> (rem >= 3'd2 && rem <= 3'd5), "overlong check w/o lead")
  `U8D_ASSERT(a_drop_end, drop_end_now |-> (drop && step.item.last_of_string), "stray drop end")
  `U8D_ASSERT(a_last_clears, last_now |=> (rem == 3'd0 && !drop && !chk), "state kept past end")

endmodule

>>> hw/rtl/u8d_out_stage.sv
// Result register of the UTF-8 decoder; holds a result while stalled.
// Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_out_stage import u8d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  u8d_step_t   step,
  input  logic        cp_stall,
  output logic        cp_valid,
  output u8d_result_t cp_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_valid <= 1'b0;
    end else if (fire && step.emit) begin
      cp_valid <= 1'b1;
    end else if (!cp_stall) begin
      cp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step.emit) begin
      cp_data <= step.item;
    end
  end

endmodule
